>>> rtl/adpcm_4bit_encoder_unit_assert.svh
// ----------------------------------------------------------------------------
// ADPCM encoder assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in rst.
// ----------------------------------------------------------------------------
`ifndef ADPCM_4BIT_ENCODER_UNIT_ASSERT_SVH
`define ADPCM_4BIT_ENCODER_UNIT_ASSERT_SVH

// Same-cycle implication.
`define ADPCM_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define ADPCM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/adpcm4_pkg.sv
// ----------------------------------------------------------------------------
// ADPCM encoder package
// Step table, index adaptation, controller states and datapath commands.
// ----------------------------------------------------------------------------
package adpcm4_pkg;

  localparam int unsigned STEP_COUNT = 89;
  localparam logic [6:0] MAX_INDEX = 7'd88;
  localparam logic signed [17:0] PRED_MAX = 18'sd32767;
  localparam logic signed [17:0] PRED_MIN = -18'sd32768;

  localparam logic [14:0] STEP_TABLE [0:STEP_COUNT-1] = '{
    15'd7, 15'd8, 15'd9, 15'd10, 15'd11, 15'd12, 15'd13, 15'd14, 15'd16, 15'd17,
    15'd19, 15'd21, 15'd23, 15'd25, 15'd28, 15'd31, 15'd34, 15'd37, 15'd41, 15'd45,
    15'd50, 15'd55, 15'd60, 15'd66, 15'd73, 15'd80, 15'd88, 15'd97, 15'd107,
    15'd118, 15'd130, 15'd143, 15'd157, 15'd173, 15'd190, 15'd209, 15'd230,
    15'd253, 15'd279, 15'd307, 15'd337, 15'd371, 15'd408, 15'd449, 15'd494,
    15'd544, 15'd598, 15'd658, 15'd724, 15'd796, 15'd876, 15'd963, 15'd1060,
    15'd1166, 15'd1282, 15'd1411, 15'd1552, 15'd1707, 15'd1878, 15'd2066,
    15'd2272, 15'd2499, 15'd2749, 15'd3024, 15'd3327, 15'd3660, 15'd4026,
    15'd4428, 15'd4871, 15'd5358, 15'd5894, 15'd6484, 15'd7132, 15'd7845,
    15'd8630, 15'd9493, 15'd10442, 15'd11487, 15'd12635, 15'd13899, 15'd15289,
    15'd16818, 15'd18500, 15'd20350, 15'd22385, 15'd24623, 15'd27086, 15'd29794,
    15'd32767
  };

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_BIT2 = 4'b0010,
    ST_BIT1 = 4'b0100,
    ST_BIT0 = 4'b1000
  } state_t;

  typedef struct packed {
    logic       load;     // capture sample, difference and step size
    logic       trial;    // apply one quantizer bit decision
    logic [1:0] bit_sel;  // magnitude bit under test
    logic       commit;   // final bit, predictor and index update, result out
  } adpcm4_cmd_t;

  function automatic logic [14:0] step_size(input logic [6:0] idx);
    return STEP_TABLE[idx];
  endfunction

  function automatic logic signed [7:0] index_move(input logic [2:0] mag);
    logic signed [7:0] mv;
    case (mag)
      3'd4:    mv = 8'sd2;
      3'd5:    mv = 8'sd4;
      3'd6:    mv = 8'sd6;
      3'd7:    mv = 8'sd8;
      default: mv = -8'sd1;
    endcase
    return mv;
  endfunction

endpackage

>>> rtl/adpcm4_stream_if.sv
// ----------------------------------------------------------------------------
// ADPCM encoder stream interfaces
// Valid/ready channels for PCM samples in and ADPCM codes out.
// ----------------------------------------------------------------------------
interface adpcm4_pcm_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] sample;
  logic               start_of_buffer;

  modport source (output valid, output sample, output start_of_buffer, input ready);
  modport sink (input valid, input sample, input start_of_buffer, output ready);
endinterface

interface adpcm4_code_if;
  logic       valid;
  logic       ready;
  logic [3:0] code;
  logic       high_nibble;

  modport source (output valid, output code, output high_nibble, input ready);
  modport sink (input valid, input code, input high_nibble, output ready);
endinterface

>>> rtl/adpcm4_ctrl.sv
// ----------------------------------------------------------------------------
// ADPCM encoder controller
// Sequences load and three quantizer steps, the last with commit; owns the output valid.
// ----------------------------------------------------------------------------
`include "adpcm_4bit_encoder_unit_assert.svh"

module adpcm4_ctrl (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  output logic                     out_valid,
  input  logic                     out_ready,
  output adpcm4_pkg::adpcm4_cmd_t  cmd
);
  import adpcm4_pkg::*;

  state_t state;
  state_t state_next;
  logic   in_fire;
  logic   slot_free;

  assign in_ready  = (state == ST_IDLE);
  assign in_fire   = in_valid && in_ready;
  // The result register may be refilled in the cycle its transaction completes.
  assign slot_free = !out_valid || out_ready;

  always_comb begin
    cmd         = '0;
    state_next  = state;
    case (state)
      ST_IDLE: begin
        cmd.load = in_fire;
        if (in_fire) begin
          state_next = ST_BIT2;
        end
      end
      ST_BIT2: begin
        cmd.trial   = 1'b1;
        cmd.bit_sel = 2'd2;
        state_next  = ST_BIT1;
      end
      ST_BIT1: begin
        cmd.trial   = 1'b1;
        cmd.bit_sel = 2'd1;
        state_next  = ST_BIT0;
      end
      ST_BIT0: begin
        cmd.bit_sel = 2'd0;
        cmd.commit  = slot_free;
        if (slot_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.commit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  `ADPCM_ASSERT_NEXT(a_accept_starts, in_fire, state == ST_BIT2, "accept did not start quantizer")
  `ADPCM_ASSERT_IMPLY(a_commit_free, cmd.commit, slot_free, "commit overwrote pending result")
  `ADPCM_ASSERT_NEXT(a_commit_valid, cmd.commit, out_valid, "commit did not raise valid")
  `ADPCM_ASSERT_IMPLY(a_rose_commit, $rose(out_valid), $past(cmd.commit), "valid rose without commit")

endmodule

>>> rtl/adpcm4_datapath.sv
// ----------------------------------------------------------------------------
// ADPCM encoder datapath
// Difference, successive-approximation quantizer, predictor and step index.
// ----------------------------------------------------------------------------
module adpcm4_datapath (
  input  logic                     clk,
  input  logic                     rst,
  input  adpcm4_pkg::adpcm4_cmd_t  cmd,
  input  logic signed [15:0]       sample,
  input  logic                     start_of_buffer,
  output logic [3:0]               code,
  output logic                     high_nibble
);
  import adpcm4_pkg::*;

  // Architectural state.
  logic signed [15:0] pred;
  logic [6:0]         index;
  logic               odd;

  // Per-sample working registers.
  logic [15:0] abs_diff;
  logic        sign;
  logic [14:0] step;
  logic [17:0] acc;
  logic [2:0]  mag;

  logic signed [15:0] pred_eff;
  logic [6:0]         idx_raw;
  logic [6:0]         idx_eff;
  logic signed [16:0] diff;
  logic [16:0]        diff_mag;

  logic [17:0]        trial;
  logic               take;
  logic [17:0]        acc_f;
  logic [2:0]         mag_f;
  logic [16:0]        recon;
  logic signed [17:0] pred_sum;
  logic signed [15:0] pred_next;
  logic signed [7:0]  index_sum;
  logic [6:0]         index_next;

  // A start-of-buffer sample is coded against cleared state.
  assign pred_eff = start_of_buffer ? 16'sd0 : pred;
  assign idx_raw  = start_of_buffer ? 7'd0 : index;
  assign idx_eff  = (idx_raw > MAX_INDEX) ? MAX_INDEX : idx_raw;
  assign diff     = 17'(sample) - 17'(pred_eff);
  assign diff_mag = diff[16] ? (17'd0 - 17'(diff)) : 17'(diff);

  // Magnitude search: test 4*|diff| >= (mag + 2^k) * step, one bit per cycle while commit is not held.
  assign trial = acc + (18'(step) << cmd.bit_sel);
  assign take  = {abs_diff, 2'b00} >= trial;
  assign acc_f = take ? trial : acc;
  assign mag_f = {mag[2:1], take};

  assign recon    = 17'(acc_f[17:2]) + 17'(step[14:3]);
  assign pred_sum = sign ? (18'(pred) - 18'(recon)) : (18'(pred) + 18'(recon));

  always_comb begin
    if (pred_sum > PRED_MAX) begin
      pred_next = 16'(PRED_MAX);
    end else if (pred_sum < PRED_MIN) begin
      pred_next = 16'(PRED_MIN);
    end else begin
      pred_next = 16'(pred_sum);
    end
  end

  assign index_sum = $signed({1'b0, index}) + index_move(mag_f);

  always_comb begin
    if (index_sum < 8'sd0) begin
      index_next = 7'd0;
    end else if (index_sum > $signed({1'b0, MAX_INDEX})) begin
      index_next = MAX_INDEX;
    end else begin
      index_next = 7'(index_sum);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pred  <= '0;
      index <= '0;
      odd   <= 1'b0;
    end else if (cmd.load) begin
      pred  <= pred_eff;
      index <= idx_eff;
      if (start_of_buffer) begin
        odd <= 1'b0;
      end
    end else if (cmd.commit) begin
      pred  <= pred_next;
      index <= index_next;
      odd   <= ~odd;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      abs_diff <= diff_mag[15:0];
      sign     <= diff[16];
      step     <= step_size(idx_eff);
      acc      <= '0;
      mag      <= '0;
    end else if (cmd.trial && take) begin
      acc <= trial;
      mag <= mag | (3'b001 << cmd.bit_sel);
    end
    if (cmd.commit) begin
      code        <= {sign, mag_f};
      high_nibble <= ~odd;
    end
  end

endmodule

>>> rtl/adpcm_4bit_encoder_unit.sv
// A sample is accepted in ST_IDLE (the load cycle) and the next one only after commit.
// The three-step magnitude search in ST_BIT2, ST_BIT1 and ST_BIT0 (one compare per cycle,
// while commit is not held) ends in a step that also updates the predictor.
// A waiting result does not block the next sample unless it is still held at commit.
// Reset clears the predictor, step index and nibble position and empties the output.
// ----------------------------------------------------------------------------
// ADPCM 4-bit encoder
// Top level: controller and datapath for sign-magnitude IMA-style encoding.
// ----------------------------------------------------------------------------
module adpcm_4bit_encoder_unit (
  input logic          clk,
  input logic          rst,
  adpcm4_pcm_if.sink   pcm,
  adpcm4_code_if.source adpcm
);
  import adpcm4_pkg::*;

  adpcm4_cmd_t cmd;

  adpcm4_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (pcm.valid),
    .in_ready  (pcm.ready),
    .out_valid (adpcm.valid),
    .out_ready (adpcm.ready),
    .cmd       (cmd)
  );

  adpcm4_datapath u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .sample          (pcm.sample),
    .start_of_buffer (pcm.start_of_buffer),
    .code            (adpcm.code),
    .high_nibble     (adpcm.high_nibble)
  );

endmodule

>>> tb/adpcm_code_checker.sv
// ----------------------------------------------------------------------------
// ADPCM encoder code checker
// Watches both stream channels, predicts the 4-bit code and nibble position
// of every accepted PCM sample, and compares each accepted code in order.
// ----------------------------------------------------------------------------
module adpcm_code_checker (
  input  logic   clk,
  input  logic   rst,
  adpcm4_pcm_if  pcm,
  adpcm4_code_if adpcm,
  output int     mismatches,
  output int     codes_pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import adpcm4_pkg::*;

  typedef struct packed {
    logic [3:0] code;
    logic       high_nibble;
  } nibble_t;

  localparam int INDEX_ADJUST [8] = '{-1, -1, -1, -1, 2, 4, 6, 8};

  // Encoder state as the block should hold it.
  logic signed [15:0] pred_sample;
  logic [6:0]         step_idx;
  logic               odd_pos;

  nibble_t code_queue [$];

  task automatic report(input string what, input int got, input int want);
    $display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
    mismatches++;
  endtask

  function automatic nibble_t encode_sample(input logic signed [15:0] s, input logic sob);
    nibble_t    res;
    logic [6:0] idx;
    logic       neg;
    int         step, diff, mag, recon, nxt, ni;
    if (sob) begin
      pred_sample = '0;
      step_idx    = '0;
      odd_pos     = 1'b0;
    end
    idx  = (step_idx > MAX_INDEX) ? MAX_INDEX : step_idx;
    step = int'(STEP_TABLE[idx]);
    diff = int'(s) - int'(pred_sample);
    neg  = (diff < 0);
    if (neg) begin
      diff = -diff;
    end
    mag = (4 * diff) / step;
    if (mag > 7) begin
      mag = 7;
    end
    recon = (step * mag) / 4 + step / 8;
    if (neg) begin
      recon = -recon;
    end
    nxt = int'(pred_sample) + recon;
    if (nxt > int'(PRED_MAX)) begin
      nxt = int'(PRED_MAX);
    end else if (nxt < int'(PRED_MIN)) begin
      nxt = int'(PRED_MIN);
    end
    pred_sample = nxt[15:0];
    ni = int'(idx) + INDEX_ADJUST[mag];
    if (ni < 0) begin
      ni = 0;
    end else if (ni > int'(MAX_INDEX)) begin
      ni = int'(MAX_INDEX);
    end
    step_idx = ni[6:0];
    res.code        = {neg, mag[2:0]};
    res.high_nibble = ~odd_pos;
    odd_pos         = ~odd_pos;
    return res;
  endfunction

  initial begin
    mismatches    = 0;
    codes_pending = 0;
    pred_sample   = '0;
    step_idx      = '0;
    odd_pos       = 1'b0;
  end

  always @(posedge clk) begin
    nibble_t want;
    if (rst) begin
      pred_sample = '0;
      step_idx    = '0;
      odd_pos     = 1'b0;
      code_queue.delete();
    end else begin
      if (adpcm.valid && adpcm.ready) begin
        if (code_queue.size() == 0) begin
          // A code transaction arrived while no sample was outstanding.
          report("outstanding samples", 0, 1);
        end else begin
          want = code_queue.pop_front();
          if (adpcm.code !== want.code) begin
            report("code", adpcm.code, want.code);
          end
          if (adpcm.high_nibble !== want.high_nibble) begin
            report("high_nibble", adpcm.high_nibble, want.high_nibble);
          end
        end
      end
      if (pcm.valid && pcm.ready) begin
        code_queue.push_back(encode_sample(pcm.sample, pcm.start_of_buffer));
      end
    end
    codes_pending = code_queue.size();
  end

endmodule

>>> tb/tb_top.sv
// ----------------------------------------------------------------------------
// ADPCM encoder testbench top
// Drives directed and random PCM sample streams with random gaps and stalls
// into the encoder, and gives the verdict from the checker's mismatch and pending-code counts.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DIRECTED_COUNT = 22;
  localparam int TOTAL_SAMPLES  = DIRECTED_COUNT + 1250;
  localparam int HOLDOFF_AT     = 400;
  localparam int HOLDOFF_CYCLES = 300;
  localparam int DRAIN_AT       = 800;
  localparam int IDLE_LIMIT     = 5000;
  localparam int TAIL_CYCLES    = 12;

  localparam logic [15:0] DIRECTED_SAMPLE [DIRECTED_COUNT] = '{
    16'h0000, 16'h0000, 16'hffff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff,
    16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h7fff, 16'h8000, 16'h5555, 16'haaaa,
    16'h8000, 16'h8000, 16'h0000, 16'h0001, 16'hfffe, 16'h0003
  };
  localparam logic DIRECTED_SOB [DIRECTED_COUNT] = '{
    1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0,
    1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
    1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0
  };

  logic clk;
  logic rst;
  int   mismatches;
  int   codes_pending;
  int   sent_count;
  bit   holdoff_done;
  int   idle_cycles;

  adpcm4_pcm_if  pcm_ch ();
  adpcm4_code_if code_ch ();

  adpcm_4bit_encoder_unit uut (
    .clk   (clk),
    .rst   (rst),
    .pcm   (pcm_ch),
    .adpcm (code_ch)
  );

  adpcm_code_checker chk (
    .clk           (clk),
    .rst           (rst),
    .pcm           (pcm_ch),
    .adpcm         (code_ch),
    .mismatches    (mismatches),
    .codes_pending (codes_pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Offers one sample after the idle gap given by gap and holds it until accepted.
  // Called and returns at a falling edge; valid stays high for a following item.
  task automatic send_sample(input logic [15:0] s, input logic sob, input int gap);
    if (gap > 0) begin
      pcm_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    pcm_ch.sample          = s;
    pcm_ch.start_of_buffer = sob;
    pcm_ch.valid           = 1'b1;
    do @(posedge clk); while (!pcm_ch.ready);
    sent_count++;
    @(negedge clk);
  endtask

  task automatic wait_all_codes();
    pcm_ch.valid = 1'b0;
    while (codes_pending != 0) @(negedge clk);
  endtask

  // Stimulus.
  initial begin
    int  level;
    int  span;
    int  kind;
    int  seg_len;
    int  gap;
    int  r;
    bit  burst;
    bit  sob;
    logic [15:0] s;
    rst                    = 1'b1;
    pcm_ch.valid           = 1'b0;
    pcm_ch.sample          = '0;
    pcm_ch.start_of_buffer = 1'b0;
    sent_count             = 0;
    level                  = 0;
    repeat (4) @(negedge clk);
    rst = 1'b0;

    for (int i = 0; i < DIRECTED_COUNT; i++) begin
      send_sample(DIRECTED_SAMPLE[i], DIRECTED_SOB[i], (i % 5 == 4) ? 3 : 0);
    end
    wait_all_codes();

    // Random part: buffers of smooth audio-like walks, plus noise and extremes.
    while (sent_count < TOTAL_SAMPLES) begin
      kind    = $urandom_range(0, 9);
      seg_len = $urandom_range(10, 60);
      burst   = ($urandom_range(0, 9) < 3);
      span    = 1 << $urandom_range(0, 14);
      sob     = ($urandom_range(0, 9) < 4);
      for (int k = 0; k < seg_len && sent_count < TOTAL_SAMPLES; k++) begin
        if (sent_count == DRAIN_AT) begin
          wait_all_codes();
        end
        case (kind)
          6, 7: begin
            s = $urandom;
          end
          8: begin
            s = $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
          end
          9: begin
            s = level[15:0] + 16'($urandom_range(0, 2)) - 16'd1;
          end
          default: begin
            level = level + int'($urandom_range(0, 2 * span)) - span;
            if (level > 32767) begin
              level = 32767;
            end else if (level < -32768) begin
              level = -32768;
            end
            s = level[15:0];
          end
        endcase
        if (k > 0) begin
          sob = ($urandom_range(0, 49) == 0);
        end
        r = $urandom_range(0, 99);
        if (burst || r < 60) begin
          gap = 0;
        end else if (r < 95) begin
          gap = $urandom_range(1, 3);
        end else begin
          gap = $urandom_range(10, 50);
        end
        send_sample(s, sob, gap);
      end
    end

    wait_all_codes();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && codes_pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Code receiver: random stalls, fast phases and one long hold-off.
  initial begin
    int stall;
    int phase_left;
    int r;
    bit fast;
    code_ch.ready = 1'b0;
    holdoff_done  = 1'b0;
    stall         = 0;
    phase_left    = 0;
    fast          = 1'b0;
    wait (!rst);
    @(negedge clk);
    forever begin
      if (!holdoff_done && sent_count >= HOLDOFF_AT) begin
        code_ch.ready = 1'b0;
        repeat (HOLDOFF_CYCLES) @(negedge clk);
        holdoff_done = 1'b1;
      end
      if (phase_left == 0) begin
        fast       = ($urandom_range(0, 3) == 0);
        phase_left = $urandom_range(50, 300);
      end
      phase_left--;
      if (stall > 0) begin
        stall--;
        code_ch.ready = 1'b0;
      end else if (fast) begin
        code_ch.ready = 1'b1;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 3) begin
          stall         = $urandom_range(10, 40);
          code_ch.ready = 1'b0;
        end else if (r < 30) begin
          code_ch.ready = 1'b0;
        end else begin
          code_ch.ready = 1'b1;
        end
      end
      @(negedge clk);
    end
  end

  // Watchdog: ends the run if no transaction happens on either channel for too long.
  initial idle_cycles = 0;

  always @(posedge clk) begin
    if (rst || (pcm_ch.valid && pcm_ch.ready) || (code_ch.valid && code_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles + 1 >= IDLE_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

endmodule

>>> files.f
+incdir+rtl
rtl/adpcm4_pkg.sv
rtl/adpcm4_stream_if.sv
rtl/adpcm4_ctrl.sv
rtl/adpcm4_datapath.sv
rtl/adpcm_4bit_encoder_unit.sv
tb/adpcm_code_checker.sv
tb/tb_top.sv
